/* sv/bcvu_pkg.sv */
`timescale 1ns / 1ps
// bcvu_pkg: shared types and constants of the compressed value unpacker
// used by bcvu_core and block_compressed_value_unpacker_unit; depends on nothing

package bcvu_pkg;

	// register indexes, selected by paddr[2]
	localparam logic REG_VALUE_BITS  = 1'b0;
	localparam logic REG_FIRST_BLOCK = 1'b1;

	localparam logic [5:0] VALUE_BITS_RST  = 6'd8;
	localparam logic [5:0] FIRST_BLOCK_RST = 6'd0;

	localparam logic [3:0] BYTE_BITS    = 4'd8;
	localparam logic [2:0] BLOCKS_FULL  = 3'd4;
	localparam logic [6:0] MIN_BLOCKED  = 7'd3;

	// control from the byte sequencer to the bit decoder
	typedef struct packed {
		logic       step;
		logic       bit_in;
		logic [3:0] avail;
		logic       clr;
		logic       cut;
	} bcvu_ctl_t;

	// decoder result for the current bit
	typedef struct packed {
		logic        vld;
		logic [31:0] value;
		logic        prog;
	} bcvu_res_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_FIN  = 3'b100
	} bcvu_state_t;

endpackage

/* sv/bcvu_ifs.sv */
`timescale 1ns / 1ps
// bcvu channel interfaces: byte input channel and value output channel
// valid/ready handshake; depends on nothing

interface bcvu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, data_byte, end_of_buffer, input ready);
	modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface bcvu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        cut_short;
	logic        last;

	modport source (output valid, value, cut_short, last, input ready);
	modport sink (input valid, value, cut_short, last, output ready);
endinterface

/* sv/bcvu_core.sv */
`timescale 1ns / 1ps
// bcvu_core: bit-serial decoder, consumes one stream bit per step
// depends on bcvu_pkg

module bcvu_core #(
	parameter int MAX_VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [5:0]            value_bits,
	input  logic [5:0]            first_block_size,
	input  bcvu_pkg::bcvu_ctl_t   ctl,
	output bcvu_pkg::bcvu_res_t   res
);
	import bcvu_pkg::*;

	localparam int CW = $clog2(MAX_VALUE_BITS + 1);
	localparam int IW = $clog2(MAX_VALUE_BITS);

	logic [MAX_VALUE_BITS-1:0] partial_q;
	logic [CW-1:0]             need_q, blk_q, left_q;
	logic [2:0]                blocks_q;
	logic                      mark_q, top_q, prog_q, inch_q;
	logic [IW-1:0]             wp_q;

	logic [6:0]                vb7, fb7, nb7, bs7;
	logic [CW-1:0]             nb, bs;
	logic [CW-1:0]             e_need, e_blk, e_left, pos, k, avail_cw, wp_sum;
	logic [CW-1:0]             need_nx, left_nx, blk_nx, left_mark;
	logic [2:0]                e_blocks, blocks_nx;
	logic                      e_mark, e_top, first;
	logic [MAX_VALUE_BITS-1:0] e_part, part_set, fill, res_src;
	logic [MAX_VALUE_BITS+31:0] wide;
	logic [IW-1:0]             wp;

	// effective width and first block size
	always_comb begin
		vb7 = {1'b0, value_bits};
		fb7 = {1'b0, first_block_size};
		if (value_bits == 6'd0) begin
			nb7 = 7'd1;
		end else if (vb7 > 7'(MAX_VALUE_BITS)) begin
			nb7 = 7'(MAX_VALUE_BITS);
		end else begin
			nb7 = vb7;
		end
		if (first_block_size == 6'd0 || fb7 > nb7 || nb7 < MIN_BLOCKED) begin
			bs7 = nb7;
		end else begin
			bs7 = fb7;
		end
		nb = CW'(nb7);
		bs = CW'(bs7);
	end

	// state as seen by this bit, with a value start folded in
	always_comb begin
		e_need   = prog_q ? need_q : nb;
		e_blk    = prog_q ? blk_q : bs;
		e_left   = prog_q ? left_q : bs;
		e_blocks = prog_q ? blocks_q : 3'd0;
		e_mark   = prog_q & mark_q;
		e_top    = prog_q & top_q;
		e_part   = prog_q ? partial_q : '0;
		first    = !prog_q || !inch_q || (ctl.avail == BYTE_BITS);

		pos      = nb - e_need;
		avail_cw = CW'(ctl.avail);
		k        = (avail_cw < e_left) ? avail_cw : e_left;
		wp_sum   = pos + k - CW'(1);
		wp       = first ? IW'(wp_sum) : wp_q;

		need_nx   = e_need - CW'(1);
		left_nx   = e_left - CW'(1);
		left_mark = (e_blk < e_need) ? e_blk : e_need;
		blocks_nx = (e_blocks < BLOCKS_FULL) ? e_blocks + 3'd1 : e_blocks;
		if (blocks_nx >= BLOCKS_FULL) begin
			blk_nx = nb;
		end else if (e_blk > CW'(2)) begin
			blk_nx = e_blk >> 1;
		end else begin
			blk_nx = e_blk;
		end

		for (int i = 0; i < MAX_VALUE_BITS; i++) begin
			part_set[i] = e_part[i] | (ctl.bit_in && (wp == IW'(i)));
			fill[i]     = e_top && (CW'(i) >= pos) && (CW'(i) < nb);
		end

		res_src   = e_mark ? (e_part | fill) : part_set;
		wide      = {32'b0, res_src};
		res.value = wide[31:0];
		res.vld   = ctl.step && (e_mark ? !ctl.bit_in : (need_nx == '0));
		res.prog  = prog_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q   <= 1'b0;
			mark_q   <= 1'b0;
			inch_q   <= 1'b0;
			blocks_q <= '0;
			left_q   <= '0;
		end else if (ctl.clr || ctl.cut) begin
			prog_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (ctl.step) begin
			if (e_mark) begin
				if (!ctl.bit_in) begin
					prog_q <= 1'b0;
				end else begin
					mark_q <= 1'b0;
					left_q <= left_mark;
					inch_q <= 1'b0;
				end
			end else begin
				prog_q   <= (need_nx != '0);
				mark_q   <= (left_nx == '0) && (need_nx != '0);
				inch_q   <= (left_nx != '0);
				left_q   <= left_nx;
				blocks_q <= (left_nx == '0) ? blocks_nx : e_blocks;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.clr && !ctl.cut && !e_mark) begin
			partial_q <= part_set;
			need_q    <= need_nx;
			blk_q     <= (left_nx == '0) ? blk_nx : e_blk;
			top_q     <= first ? ctl.bit_in : top_q;
			wp_q      <= wp - IW'(1);
		end
	end

endmodule

/* sv/block_compressed_value_unpacker_unit.sv */
`timescale 1ns / 1ps
// block_compressed_value_unpacker_unit: top level, APB registers, byte sequencer,
// pending result and output register; depends on bcvu_pkg, bcvu_ifs, bcvu_core
// a result waits in the pending register until a next result, a cut or the byte-end
// flush moves it to the output register; a new byte is taken only after the last is
// flushed, and the decoder consumes one bit per cycle unless both registers are full
// arst_n clears registers to value_bits 8, first_block_size 0, and no value in progress

module block_compressed_value_unpacker_unit #(
	parameter int MAX_VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bcvu_in_if.sink     din,
	bcvu_out_if.source  dout
);
	import bcvu_pkg::*;

	bcvu_state_t state_q;
	logic [5:0]  vb_q, fbs_q;
	logic [7:0]  sr_q;
	logic [3:0]  cnt_q;
	logic        eob_q;
	logic        pvld_q, pcut_q;
	logic [31:0] pval_q;
	logic        ovld_q, ocut_q, olast_q;
	logic [31:0] oval_q;

	bcvu_ctl_t ctl;
	bcvu_res_t res;

	logic wr, out_free, can_step, cut_need, fin_go, cut_go, flush_go;
	logic load_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_FIRST_BLOCK) ? {26'b0, fbs_q} : {26'b0, vb_q};

	assign din.ready      = (state_q == S_IDLE);
	assign dout.valid     = ovld_q;
	assign dout.value     = oval_q;
	assign dout.cut_short = ocut_q;
	assign dout.last      = olast_q;

	assign out_free = !ovld_q || dout.ready;
	assign can_step = (state_q == S_RUN) && (!pvld_q || out_free);
	assign cut_need = (state_q == S_FIN) && eob_q && res.prog;
	assign fin_go   = !pvld_q || out_free;
	assign cut_go   = cut_need && fin_go;
	assign flush_go = (state_q == S_FIN) && !cut_need && pvld_q && out_free;
	assign load_out = (can_step && res.vld && pvld_q) || (cut_go && pvld_q) || flush_go;

	assign ctl.step   = can_step;
	assign ctl.bit_in = sr_q[7];
	assign ctl.avail  = cnt_q;
	assign ctl.clr    = wr;
	assign ctl.cut    = cut_go;

	bcvu_core #(
		.MAX_VALUE_BITS(MAX_VALUE_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.value_bits      (vb_q),
		.first_block_size(fbs_q),
		.ctl             (ctl),
		.res             (res)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q  <= VALUE_BITS_RST;
			fbs_q <= FIRST_BLOCK_RST;
		end else if (wr) begin
			if (paddr[2] == REG_FIRST_BLOCK) begin
				fbs_q <= pwdata[5:0];
			end else begin
				vb_q <= pwdata[5:0];
			end
		end
	end

	// byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			eob_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						cnt_q   <= BYTE_BITS;
						eob_q   <= din.end_of_buffer;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (can_step) begin
						cnt_q <= cnt_q - 4'd1;
						if (cnt_q == 4'd1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (cut_go) begin
						eob_q <= 1'b0;
					end else if (!cut_need && (!pvld_q || out_free)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			sr_q <= din.data_byte;
		end else if (can_step) begin
			sr_q <= {sr_q[6:0], 1'b0};
		end
	end

	// pending result waits until it is known whether it is the last of its byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= 1'b0;
		end else if ((can_step && res.vld) || cut_go) begin
			pvld_q <= 1'b1;
		end else if (flush_go) begin
			pvld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_step && res.vld) begin
			pval_q <= res.value;
			pcut_q <= 1'b0;
		end else if (cut_go) begin
			pval_q <= '0;
			pcut_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (dout.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			oval_q  <= pval_q;
			ocut_q  <= pcut_q;
			olast_q <= flush_go;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |-> !pvld_q)
		else $error("byte accepted while a result is still pending");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q != 4'd0))
		else $error("decoder running with no bits left in the byte");

	a_cut_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.cut_short) |-> dout.last)
		else $error("cut short beat is not the last of its byte");

	a_cut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.cut_short) |-> (dout.value == 32'd0))
		else $error("cut short beat carries a nonzero value");

	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		(can_step && res.vld && pvld_q) |-> out_free)
		else $error("pending result pushed into a full output register");

endmodule

/* test/block_compressed_value_unpacker_unit_tb.sv */
`timescale 1ns / 1ps
// block_compressed_value_unpacker_unit_tb: drives packed bytes and register writes,
// checks every decoded value against an in-bench unpacking predictor
// depends on bcvu_pkg, bcvu_ifs and block_compressed_value_unpacker_unit

module block_compressed_value_unpacker_unit_tb;
	import bcvu_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic        cut_short;
		logic        last;
	} value_beat_t;

	typedef enum logic {ROW_BYTE, ROW_SETUP} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        eob;
		logic        typed;
		logic [31:0] value;
		logic        cut;
		logic [5:0]  width_set;
		logic [5:0]  block_set;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bcvu_in_if  in_ch ();
	bcvu_out_if out_ch ();

	block_compressed_value_unpacker_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.din     (in_ch),
		.dout    (out_ch)
	);

	value_beat_t expected_values[$];
	value_beat_t byte_values[$];
	stim_row_t   directed_rows[$];
	int          mismatches;

	// predictor state
	logic [5:0]  cfg_value_bits;
	logic [5:0]  cfg_first_block;
	logic [63:0] acc;
	logic [5:0]  need;
	logic [5:0]  blk_size;
	logic [5:0]  blk_left;
	logic [2:0]  blk_count;
	logic        want_marker;
	logic        top_bit;
	logic        busy;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [63:0] ones(input int k);
		return (k >= 64) ? '1 : (64'd1 << k) - 64'd1;
	endfunction

	function automatic logic [5:0] width_now();
		if (cfg_value_bits == 6'd0) begin
			return 6'd1;
		end
		if (cfg_value_bits > 6'd32) begin
			return 6'd32;
		end
		return cfg_value_bits;
	endfunction

	function automatic void reset_model();
		cfg_value_bits = VALUE_BITS_RST;
		cfg_first_block = FIRST_BLOCK_RST;
		acc = '0;
		need = VALUE_BITS_RST;
		blk_size = FIRST_BLOCK_RST;
		blk_left = '0;
		blk_count = '0;
		want_marker = 1'b0;
		top_bit = 1'b0;
		busy = 1'b0;
	endfunction

	function automatic void apply_register(input logic idx, input logic [5:0] v);
		if (idx == REG_VALUE_BITS) begin
			cfg_value_bits = v;
		end else begin
			cfg_first_block = v;
		end
		busy = 1'b0;
		want_marker = 1'b0;
		acc = '0;
		blk_left = '0;
		blk_count = '0;
	endfunction

	function automatic void start_value();
		logic [5:0] nb;
		logic [5:0] bs;
		nb = width_now();
		bs = cfg_first_block;
		if (bs == 6'd0 || bs > nb || 7'(nb) < MIN_BLOCKED) begin
			bs = nb;
		end
		acc = '0;
		need = nb;
		blk_size = bs;
		blk_left = bs;
		blk_count = '0;
		want_marker = 1'b0;
		top_bit = 1'b0;
		busy = 1'b1;
	endfunction

	function automatic void add_value(input logic [63:0] v, input logic cut);
		value_beat_t r;
		r.value = v[31:0];
		r.cut_short = cut;
		r.last = 1'b0;
		byte_values.push_back(r);
	endfunction

	// consumes one byte msb first, collects the values it completes and a cut-short beat at eob
	function automatic int unpack_byte(input logic [7:0] b, input logic eob);
		int avail;
		int k;
		int nb;
		logic [63:0] chunk;
		byte_values.delete();
		avail = 8;
		while (avail > 0) begin
			if (!busy) begin
				start_value();
			end
			nb = int'(width_now());
			if (want_marker) begin
				avail--;
				if (!b[avail]) begin
					if (top_bit) begin
						acc |= ones(int'(need)) << (nb - int'(need));
					end
					add_value(acc & ones(nb), 1'b0);
					busy = 1'b0;
				end else begin
					want_marker = 1'b0;
					blk_left = (blk_size < need) ? blk_size : need;
				end
				continue;
			end
			k = (avail < int'(blk_left)) ? avail : int'(blk_left);
			chunk = (64'(b) >> (avail - k)) & ones(k);
			acc |= chunk << (nb - int'(need));
			top_bit = chunk[k - 1];
			need -= 6'(k);
			blk_left -= 6'(k);
			avail -= k;
			if (blk_left == 6'd0) begin
				if (blk_count < BLOCKS_FULL) begin
					blk_count++;
				end
				if (blk_count >= BLOCKS_FULL) begin
					blk_size = 6'(nb);
				end else if (blk_size > 6'd2) begin
					blk_size = blk_size >> 1;
				end
				if (need == 6'd0) begin
					add_value(acc & ones(nb), 1'b0);
					busy = 1'b0;
				end else begin
					want_marker = 1'b1;
				end
			end
		end
		if (eob && busy) begin
			add_value(64'd0, 1'b1);
			busy = 1'b0;
			want_marker = 1'b0;
			acc = '0;
			blk_left = '0;
		end
		if (byte_values.size() > 0) begin
			byte_values[byte_values.size() - 1].last = 1'b1;
		end
		return byte_values.size();
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic write_register(input logic idx, input logic [5:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {26'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		apply_register(idx, v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {26'd0, v}) begin
			flag_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, v));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic setup_registers(input logic [5:0] width_set, input logic [5:0] block_set);
		write_register(REG_VALUE_BITS, width_set);
		write_register(REG_FIRST_BLOCK, block_set);
	endtask

	// wait for the last value, then for any byte still in the decoder
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob, input logic typed,
			input logic [31:0] v, input logic cut);
		int n;
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_buffer <= eob;
		do @(posedge clk); while (!in_ch.ready);
		n = unpack_byte(b, eob);
		if (typed) begin
			if (n == 0) begin
				flag_mismatch($sformatf("directed byte %0h yields no value", b));
			end else begin
				byte_values[0].value = v;
				byte_values[0].cut_short = cut;
			end
		end
		foreach (byte_values[i]) expected_values.push_back(byte_values[i]);
		gap = gap_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void add_byte(input logic [7:0] b, input logic eob);
		stim_row_t r;
		r = '{ROW_BYTE, b, eob, 1'b0, 32'd0, 1'b0, 6'd0, 6'd0};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_typed(input logic [7:0] b, input logic eob,
			input logic [31:0] v, input logic cut);
		stim_row_t r;
		r = '{ROW_BYTE, b, eob, 1'b1, v, cut, 6'd0, 6'd0};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_setup(input logic [5:0] w, input logic [5:0] bl);
		stim_row_t r;
		r = '{ROW_SETUP, 8'd0, 1'b0, 1'b0, 32'd0, 1'b0, w, bl};
		directed_rows.push_back(r);
	endfunction

	always @(posedge clk) begin
		value_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_values.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat value %0h cut %0b",
					out_ch.value, out_ch.cut_short));
			end else begin
				want = expected_values.pop_front();
				if (out_ch.value !== want.value) begin
					flag_mismatch($sformatf("value %0h, want %0h", out_ch.value, want.value));
				end
				if (out_ch.cut_short !== want.cut_short) begin
					flag_mismatch($sformatf("cut_short %0b, want %0b",
						out_ch.cut_short, want.cut_short));
				end
				if (out_ch.last !== want.last) begin
					flag_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
				end
			end
		end
	end

	initial begin
		int run;
		int hold;
		out_ch.ready = 1'b0;
		forever begin
			run = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
			repeat (run) begin
				@(posedge clk);
				out_ch.ready <= 1'b1;
			end
			hold = gap_len();
			repeat (hold) begin
				@(posedge clk);
				out_ch.ready <= 1'b0;
			end
		end
	end

	initial begin
		int total;
		int count;
		int pause_at;
		logic [5:0] w;
		logic [5:0] bl;
		logic [7:0] b;
		logic eob;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_of_buffer = 1'b0;
		mismatches = 0;
		total = 0;
		reset_model();

		add_typed(8'h00, 1'b0, 32'h0, 1'b0);
		add_typed(8'hFF, 1'b0, 32'hFF, 1'b0);
		add_typed(8'hA5, 1'b1, 32'hA5, 1'b0);
		add_setup(6'd32, 6'd0);
		add_byte(8'h12, 1'b0);
		add_byte(8'h34, 1'b0);
		add_byte(8'h56, 1'b0);
		add_typed(8'h78, 1'b0, 32'h78563412, 1'b0);
		add_typed(8'h9C, 1'b1, 32'h0, 1'b1);
		add_setup(6'd1, 6'd0);
		add_byte(8'hA5, 1'b0);
		add_setup(6'd0, 6'd63);
		add_byte(8'h5A, 1'b0);
		add_setup(6'd63, 6'd5);
		repeat (5) add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		add_setup(6'd16, 6'd4);
		add_typed(8'hF0, 1'b0, 32'hFFFF, 1'b0);
		add_byte(8'h7F, 1'b1);
		add_setup(6'd3, 6'd1);
		add_byte(8'h24, 1'b0);
		add_setup(6'd32, 6'd32);
		add_byte(8'h01, 1'b0);
		add_byte(8'h02, 1'b0);
		// partial value dropped by the register write
		add_setup(6'd12, 6'd3);
		add_byte(8'h80, 1'b0);
		add_byte(8'h3C, 1'b1);
		add_setup(6'd2, 6'd1);
		add_byte(8'hC6, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETUP) begin
				settle();
				setup_registers(directed_rows[i].width_set, directed_rows[i].block_set);
			end else begin
				send_byte(directed_rows[i].data, directed_rows[i].eob, directed_rows[i].typed,
					directed_rows[i].value, directed_rows[i].cut);
				total++;
			end
		end

		pause_at = total + $urandom_range(5, 20);
		while (total < 270) begin
			settle();
			case ($urandom_range(0, 3))
				0: begin
					w = 6'($urandom_range(0, 63));
					bl = 6'($urandom_range(0, 63));
				end
				1: begin
					w = 6'($urandom_range(3, 16));
					bl = 6'($urandom_range(1, w - 1));
				end
				2: begin
					w = 6'($urandom_range(17, 32));
					bl = 6'($urandom_range(1, 8));
				end
				default: begin
					w = 6'($urandom_range(1, 8));
					bl = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(1, 3));
				end
			endcase
			setup_registers(w, bl);
			count = $urandom_range(15, 35);
			if (count > 270 - total) begin
				count = 270 - total;
			end
			repeat (count) begin
				case ($urandom_range(0, 7))
					0, 1: b = 8'hFF;
					2: b = 8'h00;
					default: b = 8'($urandom_range(0, 255));
				endcase
				eob = ($urandom_range(0, 9) == 0);
				send_byte(b, eob, 1'b0, 32'd0, 1'b0);
				total++;
				if (total == pause_at || $urandom_range(0, 29) == 0) begin
					in_ch.valid <= 1'b0;
					do @(posedge clk); while (expected_values.size() != 0);
				end
			end
		end

		in_ch.valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* block_compressed_value_unpacker_unit.f */
sv/bcvu_pkg.sv
sv/bcvu_ifs.sv
sv/bcvu_core.sv
sv/block_compressed_value_unpacker_unit.sv
test/block_compressed_value_unpacker_unit_tb.sv
